FILE: rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared types and codes of the deadlock-avoiding resource allocator: the
// input and result words, operation and status codes, lane control.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int CUST_W   = 3;
  localparam int AMT_W    = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_DECLARE = 2'd2;
  localparam logic [OP_W-1:0] OP_SETPOOL = 2'd3;

  localparam logic [STATUS_W-1:0] ST_GRANTED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_WAIT        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXCEEDS     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNSAFE      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_REL_EXCEEDS = 3'd5;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [CUST_W-1:0] customer;
    logic [AMT_W-1:0]  amount_0;
    logic [AMT_W-1:0]  amount_1;
    logic [AMT_W-1:0]  amount_2;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [AMT_W-1:0]    free_0;
    logic [AMT_W-1:0]    free_1;
    logic [AMT_W-1:0]    free_2;
  } out_word_t;

  // row write and safety-check strobes broadcast to all lanes
  typedef struct packed {
    logic              wr_en;
    logic [CUST_W-1:0] wr_cust;
    logic              chk_clr;
    logic              chk_step;
  } lane_ctl_t;

endpackage

FILE: rtl/bra_lane.sv
// ----------------------------------------------------------------------------
// bra_lane
// One customer: holds its allocation and remaining-need rows and its finish
// mark, and tests its need against the working pool of the safety check.
// ----------------------------------------------------------------------------
module bra_lane #(
  parameter int RESOURCES   = 3,
  parameter int AMOUNT_BITS = 8,
  parameter int WORK_BITS   = 12,
  parameter int LANE_ID     = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bra_pkg::lane_ctl_t                     ctl,
  input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  wr_held,
  input  logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  wr_need,
  input  logic [RESOURCES-1:0][WORK_BITS-1:0]    work,
  input  logic                                   picked,
  output logic                                   fits,
  output logic                                   done,
  output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  held,
  output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]  need
);

  logic sel;

  assign sel = ctl.wr_en && (int'(ctl.wr_cust) == LANE_ID);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
      need <= '0;
      done <= 1'b0;
    end else begin
      if (sel) begin
        held <= wr_held;
        need <= wr_need;
      end
      if (ctl.chk_clr) begin
        done <= 1'b0;
      end else if (ctl.chk_step && picked) begin
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    fits = !done;
    for (int j = 0; j < RESOURCES; j++) begin
      if (WORK_BITS'(need[j]) > work[j]) fits = 1'b0;
    end
  end

endmodule

FILE: rtl/bra_merge.sv
// ----------------------------------------------------------------------------
// bra_merge
// Combines the lanes: picks the lowest-index customer that fits, gathers its
// allocation row, and reads out the rows of the addressed customer.
// ----------------------------------------------------------------------------
module bra_merge #(
  parameter int CUSTOMERS   = 8,
  parameter int RESOURCES   = 3,
  parameter int AMOUNT_BITS = 8
) (
  input  logic [CUSTOMERS-1:0]                                  fits,
  input  logic [CUSTOMERS-1:0]                                  done,
  input  logic [CUSTOMERS-1:0][RESOURCES-1:0][AMOUNT_BITS-1:0]  held_all,
  input  logic [CUSTOMERS-1:0][RESOURCES-1:0][AMOUNT_BITS-1:0]  need_all,
  input  logic [bra_pkg::CUST_W-1:0]                            customer,
  output logic [CUSTOMERS-1:0]                                  pick,
  output logic                                                  any_fit,
  output logic                                                  all_done,
  output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]                 pick_held,
  output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]                 sel_held,
  output logic [RESOURCES-1:0][AMOUNT_BITS-1:0]                 sel_need
);

  // isolate lowest set bit
  assign pick     = fits & (~fits + CUSTOMERS'(1));
  assign any_fit  = |fits;
  assign all_done = &done;

  always_comb begin
    pick_held = '0;
    sel_held  = '0;
    sel_need  = '0;
    for (int i = 0; i < CUSTOMERS; i++) begin
      if (pick[i]) pick_held = pick_held | held_all[i];
      if (int'(customer) == i) begin
        sel_held = sel_held | held_all[i];
        sel_need = sel_need | need_all[i];
      end
    end
  end

endmodule

FILE: rtl/bankers_resource_allocator_top.sv
// ----------------------------------------------------------------------------
// bankers_resource_allocator_top
// Deadlock-avoiding allocator: requests, releases, customer maximums and the
// free pool, with a safety check over one lane per customer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | word
//  --------+-----+----------------------+----------------------------------
//  in      | in  | in_valid / in_ready  | bra_pkg::in_word_t  (op, customer, amounts)
//  out     | out | out_valid / out_ready| bra_pkg::out_word_t (status, free pool)
//
// An item passes through the read, evaluate and done states before the next
// acceptance; a request that reaches the safety check also loops in the check
// state, retiring one customer per step (one shared working-pool adder).
// Reset clears the pool, all allocation and need rows; no clearing pass.
// A new word is taken while a result waits in the output register; a
// finished result waits in the done state while the output is stalled.
// ----------------------------------------------------------------------------
module bankers_resource_allocator_top #(
  parameter int CUSTOMERS   = 8,
  parameter int RESOURCES   = 3,
  parameter int AMOUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bra_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bra_pkg::out_word_t out_data
);

  localparam int WORK_BITS = AMOUNT_BITS + $clog2(CUSTOMERS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  typedef logic [RESOURCES-1:0][AMOUNT_BITS-1:0] row_t;
  typedef logic [RESOURCES-1:0][WORK_BITS-1:0]   work_row_t;

  logic [2:0]                        state, state_next;
  logic [bra_pkg::OP_W-1:0]          op;
  logic [bra_pkg::CUST_W-1:0]        cust;
  row_t                              amt;
  row_t                              cur_held, cur_need;
  row_t                              free_pool, free_next;
  work_row_t                         work, work_next;
  logic [bra_pkg::STATUS_W-1:0]      status_r, status_next;
  bra_pkg::lane_ctl_t                lane_ctl;
  row_t                              wr_held, wr_need;
  logic [2:0][bra_pkg::AMT_W-1:0]    in_amt;
  logic [2:0][bra_pkg::AMT_W-1:0]    free_out;
  bra_pkg::out_word_t                out_next;
  logic                              out_load;

  logic [CUSTOMERS-1:0]              fits, done, pick;
  logic [CUSTOMERS-1:0][RESOURCES-1:0][AMOUNT_BITS-1:0] held_all, need_all;
  logic                              any_fit, all_done;
  row_t                              pick_held, sel_held, sel_need;

  logic                              in_range, over_need, over_free, over_held;
  logic [RESOURCES-1:0][AMOUNT_BITS:0] rel_sum;

  // ---- lanes and merge -----------------------------------------------------
  for (genvar i = 0; i < CUSTOMERS; i++) begin : g_lane
    bra_lane #(
      .RESOURCES   (RESOURCES),
      .AMOUNT_BITS (AMOUNT_BITS),
      .WORK_BITS   (WORK_BITS),
      .LANE_ID     (i)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .wr_held (wr_held),
      .wr_need (wr_need),
      .work    (work),
      .picked  (pick[i]),
      .fits    (fits[i]),
      .done    (done[i]),
      .held    (held_all[i]),
      .need    (need_all[i])
    );
  end

  bra_merge #(
    .CUSTOMERS   (CUSTOMERS),
    .RESOURCES   (RESOURCES),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_merge (
    .fits      (fits),
    .done      (done),
    .held_all  (held_all),
    .need_all  (need_all),
    .customer  (cust),
    .pick      (pick),
    .any_fit   (any_fit),
    .all_done  (all_done),
    .pick_held (pick_held),
    .sel_held  (sel_held),
    .sel_need  (sel_need)
  );

  // ---- control -------------------------------------------------------------
  assign in_ready = (state == S_IDLE);
  assign in_amt   = {in_data.amount_2, in_data.amount_1, in_data.amount_0};
  assign in_range = int'(cust) < CUSTOMERS;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    over_need = 1'b0;
    over_free = 1'b0;
    over_held = 1'b0;
    for (int j = 0; j < RESOURCES; j++) begin
      if (amt[j] > cur_need[j])  over_need = 1'b1;
      if (amt[j] > free_pool[j]) over_free = 1'b1;
      if (amt[j] > cur_held[j])  over_held = 1'b1;
      rel_sum[j] = {1'b0, free_pool[j]} + {1'b0, amt[j]};
    end
  end

  always_comb begin
    state_next       = state;
    free_next        = free_pool;
    work_next        = work;
    status_next      = status_r;
    lane_ctl         = '0;
    lane_ctl.wr_cust = cust;
    wr_held          = cur_held;
    wr_need          = cur_need;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_EVAL;
      end
      S_EVAL: begin
        state_next = S_DONE;
        case (op)
          bra_pkg::OP_REQUEST: begin
            if (!in_range || over_need) begin
              status_next = bra_pkg::ST_EXCEEDS;
            end else if (over_free) begin
              status_next = bra_pkg::ST_WAIT;
            end else begin
              // tentative grant, kept only if the check passes
              lane_ctl.wr_en   = 1'b1;
              lane_ctl.chk_clr = 1'b1;
              for (int j = 0; j < RESOURCES; j++) begin
                wr_held[j]   = cur_held[j] + amt[j];
                wr_need[j]   = cur_need[j] - amt[j];
                free_next[j] = free_pool[j] - amt[j];
                work_next[j] = WORK_BITS'(free_next[j]);
              end
              state_next = S_CHECK;
            end
          end
          bra_pkg::OP_RELEASE: begin
            if (!in_range || over_held) begin
              status_next = bra_pkg::ST_REL_EXCEEDS;
            end else begin
              lane_ctl.wr_en = 1'b1;
              for (int j = 0; j < RESOURCES; j++) begin
                wr_held[j]   = cur_held[j] - amt[j];
                wr_need[j]   = cur_need[j] + amt[j];
                free_next[j] = rel_sum[j][AMOUNT_BITS] ? '1 : rel_sum[j][AMOUNT_BITS-1:0];
              end
              status_next = bra_pkg::ST_ACCEPTED;
            end
          end
          bra_pkg::OP_DECLARE: begin
            if (!in_range) begin
              status_next = bra_pkg::ST_EXCEEDS;
            end else begin
              lane_ctl.wr_en = 1'b1;
              wr_held        = '0;
              wr_need        = amt;
              status_next    = bra_pkg::ST_ACCEPTED;
            end
          end
          default: begin
            free_next   = amt;
            status_next = bra_pkg::ST_ACCEPTED;
          end
        endcase
      end
      S_CHECK: begin
        if (all_done) begin
          status_next = bra_pkg::ST_GRANTED;
          state_next  = S_DONE;
        end else if (!any_fit) begin
          // unsafe: put back the rows read before the grant
          lane_ctl.wr_en = 1'b1;
          for (int j = 0; j < RESOURCES; j++) begin
            free_next[j] = free_pool[j] + amt[j];
          end
          status_next = bra_pkg::ST_UNSAFE;
          state_next  = S_DONE;
        end else begin
          lane_ctl.chk_step = 1'b1;
          for (int j = 0; j < RESOURCES; j++) begin
            work_next[j] = work[j] + WORK_BITS'(pick_held[j]);
          end
        end
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_pool <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_pool <= free_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op   <= in_data.operation;
      cust <= in_data.customer;
      for (int j = 0; j < RESOURCES; j++) begin
        amt[j] <= AMOUNT_BITS'(in_amt[j]);
      end
    end
    if (state == S_READ) begin
      cur_held <= sel_held;
      cur_need <= sel_need;
    end
    work     <= work_next;
    status_r <= status_next;
    if (out_load) out_data <= out_next;
  end

  for (genvar j = 0; j < 3; j++) begin : g_free
    if (j < RESOURCES) begin : g_used
      assign free_out[j] = bra_pkg::AMT_W'(free_pool[j]);
    end else begin : g_unused
      assign free_out[j] = '0;
    end
  end

  always_comb begin
    out_next.status = status_r;
    out_next.free_0 = free_out[0];
    out_next.free_1 = free_out[1];
    out_next.free_2 = free_out[2];
  end

  // ---- assertions ----------------------------------------------------------
  a_accept_to_read : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_READ))
    else $error("accepted word did not start a row read");

  a_pick_onehot : assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && any_fit) |-> $onehot(pick))
    else $error("check picked other than one customer");

  a_step_in_check : assert property (@(posedge clk) disable iff (rst)
    lane_ctl.chk_step |-> (state == S_CHECK && !lane_ctl.wr_en))
    else $error("check step outside the check loop");

  a_rollback_unsafe : assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK && lane_ctl.wr_en) |=> (state == S_DONE && status_r == bra_pkg::ST_UNSAFE))
    else $error("rollback without unsafe status");

endmodule

FILE: tb/sv/allocation_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// allocation_checker
// Watches both channels of the allocator, keeps its own copy of the pool,
// holdings and needs, works out the reply to every accepted input word and
// compares each reply word against the oldest one still owed.
// ----------------------------------------------------------------------------
module allocation_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  bra_pkg::in_word_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  bra_pkg::out_word_t  out_data,
  output int                  mismatches,
  output int                  outstanding
);

  localparam int NCUST       = 8;
  localparam int NRES        = 3;
  localparam int MAX_REPORTS = 10;
  localparam int AMT_MAX     = (1 << bra_pkg::AMT_W) - 1;

  typedef struct packed {
    bra_pkg::in_word_t  cause;
    bra_pkg::out_word_t reply;
  } owed_reply_t;

  logic [bra_pkg::AMT_W-1:0] pool [NRES];
  logic [bra_pkg::AMT_W-1:0] held [NCUST][NRES];
  logic [bra_pkg::AMT_W-1:0] need [NCUST][NRES];

  owed_reply_t owed_replies[$];
  int          failures = 0;

  // every customer must be able to finish in some order, returning its
  // holding once its need fits the working pool (wide, never wraps)
  function automatic bit pool_is_safe();
    int unsigned work [NRES];
    bit          finished [NCUST];
    bit          fits;
    int          pick;
    for (int j = 0; j < NRES; j++) work[j] = pool[j];
    for (int i = 0; i < NCUST; i++) finished[i] = 1'b0;
    for (int n = 0; n < NCUST; n++) begin
      pick = -1;
      for (int i = 0; i < NCUST && pick < 0; i++) begin
        fits = !finished[i];
        for (int j = 0; j < NRES; j++)
          if (need[i][j] > work[j]) fits = 1'b0;
        if (fits) pick = i;
      end
      if (pick < 0) return 1'b0;
      for (int j = 0; j < NRES; j++) work[j] += held[pick][j];
      finished[pick] = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic bra_pkg::out_word_t allocate_step(bra_pkg::in_word_t w);
    logic [bra_pkg::AMT_W-1:0]    amt [NRES];
    logic [bra_pkg::STATUS_W-1:0] st;
    bra_pkg::out_word_t           r;
    int                           c;
    bit                           over_need, over_pool, over_held;
    int unsigned                  sum;
    amt[0] = w.amount_0;
    amt[1] = w.amount_1;
    amt[2] = w.amount_2;
    c = w.customer;
    over_need = 1'b0;
    over_pool = 1'b0;
    over_held = 1'b0;
    for (int j = 0; j < NRES; j++) begin
      if (amt[j] > need[c][j]) over_need = 1'b1;
      if (amt[j] > pool[j]) over_pool = 1'b1;
      if (amt[j] > held[c][j]) over_held = 1'b1;
    end
    case (w.operation)
      bra_pkg::OP_REQUEST: begin
        if (over_need) begin
          st = bra_pkg::ST_EXCEEDS;
        end else if (over_pool) begin
          st = bra_pkg::ST_WAIT;
        end else begin
          for (int j = 0; j < NRES; j++) begin
            pool[j]    -= amt[j];
            held[c][j] += amt[j];
            need[c][j] -= amt[j];
          end
          if (pool_is_safe()) begin
            st = bra_pkg::ST_GRANTED;
          end else begin
            // roll the tentative grant back
            for (int j = 0; j < NRES; j++) begin
              pool[j]    += amt[j];
              held[c][j] -= amt[j];
              need[c][j] += amt[j];
            end
            st = bra_pkg::ST_UNSAFE;
          end
        end
      end
      bra_pkg::OP_RELEASE: begin
        if (over_held) begin
          st = bra_pkg::ST_REL_EXCEEDS;
        end else begin
          for (int j = 0; j < NRES; j++) begin
            sum = int'(pool[j]) + int'(amt[j]);
            pool[j]    = (sum > AMT_MAX) ? bra_pkg::AMT_W'(AMT_MAX) : bra_pkg::AMT_W'(sum);
            held[c][j] -= amt[j];
            need[c][j] += amt[j];
          end
          st = bra_pkg::ST_ACCEPTED;
        end
      end
      bra_pkg::OP_DECLARE: begin
        // holding is dropped, not returned to the pool
        for (int j = 0; j < NRES; j++) begin
          need[c][j] = amt[j];
          held[c][j] = '0;
        end
        st = bra_pkg::ST_ACCEPTED;
      end
      default: begin
        for (int j = 0; j < NRES; j++) pool[j] = amt[j];
        st = bra_pkg::ST_ACCEPTED;
      end
    endcase
    r.status = st;
    r.free_0 = pool[0];
    r.free_1 = pool[1];
    r.free_2 = pool[2];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    owed_reply_t head;
    if (rst) begin
      for (int j = 0; j < NRES; j++) pool[j] = '0;
      for (int i = 0; i < NCUST; i++)
        for (int j = 0; j < NRES; j++) begin
          held[i][j] = '0;
          need[i][j] = '0;
        end
      owed_replies.delete();
    end else begin
      // reply side first: a reply can never stem from a word taken this edge
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("%0t: reply with none owed: status %0d free %0d/%0d/%0d", $realtime,
                     out_data.status, out_data.free_0, out_data.free_1, out_data.free_2);
        end else begin
          head = owed_replies.pop_front();
          if (out_data.status !== head.reply.status || out_data.free_0 !== head.reply.free_0 ||
              out_data.free_1 !== head.reply.free_1 || out_data.free_2 !== head.reply.free_2)
          begin
            failures++;
            if (failures <= MAX_REPORTS) begin
              $display("%0t: op %0d cust %0d amt %0d/%0d/%0d: expected status %0d free %0d/%0d/%0d",
                       $realtime, head.cause.operation, head.cause.customer,
                       head.cause.amount_0, head.cause.amount_1, head.cause.amount_2,
                       head.reply.status, head.reply.free_0, head.reply.free_1,
                       head.reply.free_2);
              $display("%0t:   got status %0d free %0d/%0d/%0d",
                       $realtime, out_data.status, out_data.free_0,
                       out_data.free_1, out_data.free_2);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        head.cause = in_data;
        head.reply = allocate_step(in_data);
        owed_replies.push_back(head);
      end
    end
    mismatches  <= failures;
    outstanding <= owed_replies.size();
  end

endmodule

FILE: tb/sv/bankers_resource_allocator_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bankers_resource_allocator_top_test
// Drives the allocator with a directed opening (extremes, every operation and
// status, saturation, dropped holdings) and then random request, release,
// declare and pool words mixed with raw noise, across idle and stall phases
// with one long output hold-off. Checking is done by allocation_checker.
// ----------------------------------------------------------------------------
module bankers_resource_allocator_top_test;

  localparam int RANDOM_ITEMS = 1300;
  localparam int LIMIT_CYCLES = 500000;
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 30;
  localparam int MAX_GAP      = 40;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  bra_pkg::in_word_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  bra_pkg::out_word_t out_data;

  int mismatches;
  int outstanding;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  bit long_hold_req = 1'b0;
  int cycles        = 0;

  bankers_resource_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  allocation_checker alloc_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic bra_pkg::in_word_t make_word(int op, int cust, int a0, int a1, int a2);
    bra_pkg::in_word_t w;
    w.operation = op[bra_pkg::OP_W-1:0];
    w.customer  = cust[bra_pkg::CUST_W-1:0];
    w.amount_0  = a0[bra_pkg::AMT_W-1:0];
    w.amount_1  = a1[bra_pkg::AMT_W-1:0];
    w.amount_2  = a2[bra_pkg::AMT_W-1:0];
    return w;
  endfunction

  // mostly well-formed traffic with small amounts so grants, waits and
  // unsafe refusals all come up; a tenth is raw noise over every bit
  function automatic bra_pkg::in_word_t random_word();
    int pick;
    int cust;
    pick = $urandom_range(99);
    cust = $urandom_range(7);
    if (pick < 10)
      return make_word($urandom_range(3), cust, $urandom_range(255), $urandom_range(255),
                       $urandom_range(255));
    if (pick < 13) begin
      if ($urandom_range(9) == 0)
        return make_word(bra_pkg::OP_SETPOOL, cust, $urandom_range(1) * 255,
                         $urandom_range(1) * 255, $urandom_range(1) * 255);
      return make_word(bra_pkg::OP_SETPOOL, cust, $urandom_range(60, 8),
                       $urandom_range(60, 8), $urandom_range(60, 8));
    end
    if (pick < 25)
      return make_word(bra_pkg::OP_DECLARE, cust, $urandom_range(24), $urandom_range(24),
                       $urandom_range(24));
    if (pick < 70)
      return make_word(bra_pkg::OP_REQUEST, cust, $urandom_range(8), $urandom_range(8),
                       $urandom_range(8));
    return make_word(bra_pkg::OP_RELEASE, cust, $urandom_range(6), $urandom_range(6),
                     $urandom_range(6));
  endfunction

  task automatic send_word(input bra_pkg::in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait for every owed reply
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    bra_pkg::in_word_t directed[$];
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(make_word(bra_pkg::OP_REQUEST, 0, 0, 0, 0));  // zero request, empty state
    directed.push_back(make_word(bra_pkg::OP_SETPOOL, 0, 255, 255, 255));
    directed.push_back(make_word(bra_pkg::OP_SETPOOL, 5, 0, 0, 0));
    directed.push_back(make_word(bra_pkg::OP_SETPOOL, 7, 10, 20, 30));
    directed.push_back(make_word(bra_pkg::OP_DECLARE, 0, 8, 8, 8));
    directed.push_back(make_word(bra_pkg::OP_DECLARE, 7, 255, 255, 255));
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 0, 9, 0, 0));  // over need
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 7, 11, 0, 0)); // over pool
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 0, 5, 5, 5));  // unsafe, rolled back
    directed.push_back(make_word(bra_pkg::OP_DECLARE, 7, 0, 0, 0));
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 0, 5, 5, 5));
    directed.push_back(make_word(bra_pkg::OP_RELEASE, 0, 6, 0, 0));  // more than held
    directed.push_back(make_word(bra_pkg::OP_RELEASE, 0, 5, 5, 5));
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 0, 0, 0, 0));
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 0, 2, 2, 2));
    directed.push_back(make_word(bra_pkg::OP_DECLARE, 0, 4, 4, 4));  // holding dropped
    directed.push_back(make_word(bra_pkg::OP_DECLARE, 3, 20, 20, 20));
    directed.push_back(make_word(bra_pkg::OP_SETPOOL, 0, 250, 250, 250));
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 3, 8, 8, 8));
    directed.push_back(make_word(bra_pkg::OP_SETPOOL, 0, 250, 250, 250));
    directed.push_back(make_word(bra_pkg::OP_RELEASE, 3, 8, 8, 8));  // pool saturates
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 5, 255, 255, 255));
    directed.push_back(make_word(bra_pkg::OP_RELEASE, 6, 255, 255, 255));
    directed.push_back(make_word(bra_pkg::OP_REQUEST, 7, 8'h55, 8'haa, 8'hff));
    foreach (directed[k]) send_word(directed[k]);
    drain();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          tx_idle_pct   = 0;
          rx_stall_pct  = 0;
          long_hold_req = 1'b1;
        end
        1: begin
          tx_idle_pct  = 65;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 65;
        end
        default: begin
          tx_idle_pct  = 6;
          rx_stall_pct = 6;
        end
      endcase
      repeat (RANDOM_ITEMS / 4) send_word(random_word());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
